>>> rtl/kdh_pkg.sv
// Shared types and constants for the key debounce / HID report block.
// Used by kdh_qcell and key_debounce_hid_report.
`default_nettype none

package kdh_pkg;

  // Key index as carried inside the block (one bit wider than the port).
  localparam int IDX_W  = 8;
  localparam int CODE_W = 8;
  localparam int HIST_W = 8;
  localparam int REPORT_SLOTS = 6;

  // Debounce patterns seen in the history after the new sample is merged.
  localparam logic [HIST_W-1:0] PRESS_PAT   = 8'h7F;
  localparam logic [HIST_W-1:0] RELEASE_PAT = 8'h80;

  // Request function codes.
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_LOAD   = 1'b1;

  // Report event kinds.
  localparam logic EVT_PRESS   = 1'b0;
  localparam logic EVT_RELEASE = 1'b1;

  // One recency queue slot.
  typedef struct packed {
    logic              vld;
    logic [IDX_W-1:0]  key;
    logic [CODE_W-1:0] code;
  } slot_t;

  // Command broadcast to every queue cell.
  typedef struct packed {
    logic              en;
    logic              push;
    logic              remove;
    logic              load;
    logic [IDX_W-1:0]  key;
    logic [CODE_W-1:0] code;
  } qctl_t;

endpackage

`default_nettype wire

>>> rtl/kdh_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none

module kdh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                      wdata_i,
  input  wire logic                                  re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/kdh_qcell.sv
// One slot of the recency queue: holds a key and its code, shifts toward the
// back on a push and toward the front when a key ahead of it leaves. Uses kdh_pkg.
`default_nettype none

module kdh_qcell
  import kdh_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire qctl_t ctl_i,
  input  wire slot_t left_i,
  input  wire slot_t right_i,
  input  wire logic  hit_i,
  output logic       hit_o,
  output slot_t      cur_o,
  output slot_t      nxt_o
);

  slot_t slot_q, slot_d;
  logic  match;

  assign match = slot_q.vld && (slot_q.key == ctl_i.key);
  // Removal point propagates toward the back of the queue.
  assign hit_o = hit_i | match;

  always_comb begin
    slot_d = slot_q;
    if (ctl_i.push) begin
      slot_d = left_i;
    end else if (ctl_i.remove && hit_o) begin
      slot_d = right_i;
    end else if (ctl_i.load && match) begin
      slot_d.code = ctl_i.code;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else if (ctl_i.en) begin
      slot_q <= slot_d;
    end
  end

  assign cur_o = slot_q;
  assign nxt_o = slot_d;

endmodule

`default_nettype wire

>>> rtl/key_debounce_hid_report.sv
// Key debouncer and six-slot HID report builder, top level.
// Uses kdh_pkg, kdh_ram and kdh_qcell.
//
// Usage: the input channel takes one request per cycle, either a matrix
//   sample for one key (func 0, key_down) or a layout entry for one key
//   (func 1, entry_is_modifier, entry_code). Load the layout of every key
//   before sampling it. Requests with a key index at or beyond NUM_KEYS are
//   accepted and dropped. A sample that completes a debounced press or
//   release gives one report: event kind, modifier byte and six slot
//   keycodes, most recent first, 0 for an empty slot. Other requests give none.
// Throughput: one request per cycle while the report register is free or
//   drained. The accepting edge registers the history and layout RAM reads;
//   the update stage's advancing edge updates key state and loads the report
//   register, raising out_valid_o for a report. A request to the same key as
//   the one ahead takes the forwarded write-back, not the stale RAM word.
// Reset: clears all histories and pressed flags (per-key valid bits), the
//   queue and the modifier byte at once, with no clearing pass. The layout
//   RAM is not cleared.
// Stalls: the report register holds while out_ready_i is low; the update
//   stage holds behind it, and input ready drops only when both are full.
`default_nettype none

module key_debounce_hid_report
  import kdh_pkg::*;
#(
  parameter int NUM_KEYS    = 128,
  parameter int QUEUE_SLOTS = 6
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       func_i,
  input  wire logic [6:0] key_index_i,
  input  wire logic       key_down_i,
  input  wire logic       entry_is_modifier_i,
  input  wire logic [7:0] entry_code_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            event_kind_o,
  output logic [7:0]      modifier_byte_o,
  output logic [7:0]      slot_0_o,
  output logic [7:0]      slot_1_o,
  output logic [7:0]      slot_2_o,
  output logic [7:0]      slot_3_o,
  output logic [7:0]      slot_4_o,
  output logic [7:0]      slot_5_o
);

  localparam int KW    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int ENT_W = HIST_W + 1;   // history plus pressed flag / code plus type

  // ---------------------------------------------------------------------
  // Request intake
  // ---------------------------------------------------------------------
  logic             accept;
  logic [IDX_W-1:0] key_ext;
  logic             in_live;

  assign key_ext = {1'b0, key_index_i};
  assign in_live = key_ext < IDX_W'(NUM_KEYS);
  assign accept  = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------------
  // Update stage registers
  // ---------------------------------------------------------------------
  logic              s1_vld_q, s1_vld_d;
  logic              s1_func_q;
  logic [IDX_W-1:0]  s1_key_q;
  logic              s1_down_q;
  logic              s1_ismod_q;
  logic [CODE_W-1:0] s1_code_q;
  logic              s1_live_q;
  logic              hfwd_q, lfwd_q, hv_q;
  logic [ENT_W-1:0]  hfwd_data_q, lfwd_data_q;
  logic              s1_adv;

  logic              out_vld_q, out_vld_d;
  logic              evk_q;
  logic [CODE_W-1:0] modb_q;
  logic [CODE_W-1:0] rslot_q [REPORT_SLOTS];

  logic [CODE_W-1:0] mod_q, mod_d;
  logic [NUM_KEYS-1:0] hvld_q;

  // Advance when the report register is free or being drained.
  assign s1_adv     = s1_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !s1_vld_q || s1_adv;

  // ---------------------------------------------------------------------
  // Per-key memories
  // ---------------------------------------------------------------------
  logic             hist_we, lay_we;
  logic [ENT_W-1:0] hist_wdata, lay_wdata;
  logic [ENT_W-1:0] hist_rdata, lay_rdata;
  logic [KW-1:0]    raddr, waddr;

  assign raddr = key_ext[KW-1:0];
  assign waddr = s1_key_q[KW-1:0];

  kdh_ram #(.WIDTH(ENT_W), .DEPTH(NUM_KEYS)) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (waddr),
    .wdata_i (hist_wdata),
    .re_i    (accept),
    .raddr_i (raddr),
    .rdata_o (hist_rdata)
  );

  kdh_ram #(.WIDTH(ENT_W), .DEPTH(NUM_KEYS)) u_lay_ram (
    .clk_i   (clk_i),
    .we_i    (lay_we),
    .waddr_i (waddr),
    .wdata_i (lay_wdata),
    .re_i    (accept),
    .raddr_i (raddr),
    .rdata_o (lay_rdata)
  );

  // ---------------------------------------------------------------------
  // Debounce decision
  // ---------------------------------------------------------------------
  logic [ENT_W-1:0]  hist_old, lay_cur;
  logic [HIST_W-1:0] hist_m;
  logic              was_pressed, now_pressed;
  logic              is_sample, is_load;
  logic              press_ev, release_ev, report_ev;
  logic              lay_type;
  logic [CODE_W-1:0] lay_code;

  // Forwarded write-back wins; a history entry never written reads as zero.
  assign hist_old    = hfwd_q ? hfwd_data_q : (hv_q ? hist_rdata : '0);
  assign lay_cur     = lfwd_q ? lfwd_data_q : lay_rdata;
  assign lay_type    = lay_cur[ENT_W-1];
  assign lay_code    = lay_cur[CODE_W-1:0];
  assign was_pressed = hist_old[ENT_W-1];
  assign hist_m      = hist_old[HIST_W-1:0] | {{(HIST_W-1){1'b0}}, s1_down_q};

  assign is_sample  = s1_live_q && (s1_func_q == FUNC_SAMPLE);
  assign is_load    = s1_live_q && (s1_func_q == FUNC_LOAD);
  assign press_ev   = is_sample && (hist_m == PRESS_PAT) && !was_pressed;
  assign release_ev = is_sample && (hist_m == RELEASE_PAT) && was_pressed;
  assign report_ev  = press_ev || release_ev;

  assign now_pressed = press_ev ? 1'b1 : (release_ev ? 1'b0 : was_pressed);

  assign hist_we    = s1_adv && is_sample;
  assign hist_wdata = {now_pressed, hist_m[HIST_W-2:0], 1'b0};
  assign lay_we     = s1_adv && is_load;
  assign lay_wdata  = {s1_ismod_q, s1_code_q};

  // Modifier byte update.
  always_comb begin
    mod_d = mod_q;
    if (press_ev && lay_type) begin
      mod_d = mod_q | lay_code;
    end else if (release_ev && lay_type) begin
      mod_d = mod_q & ~lay_code;
    end
  end

  // ---------------------------------------------------------------------
  // Recency queue: chain of cells
  // ---------------------------------------------------------------------
  qctl_t qctl;
  slot_t cur [QUEUE_SLOTS];
  slot_t nxt [QUEUE_SLOTS];
  logic  hit [QUEUE_SLOTS+1];
  slot_t new_slot, empty_slot;

  assign qctl.en     = s1_adv;
  assign qctl.push   = press_ev && !lay_type;
  assign qctl.remove = release_ev && !lay_type;
  assign qctl.load   = is_load;
  assign qctl.key    = s1_key_q;
  assign qctl.code   = is_load ? s1_code_q : lay_code;

  assign new_slot   = '{vld: 1'b1, key: s1_key_q, code: lay_code};
  assign empty_slot = '0;
  assign hit[0]     = 1'b0;

  for (genvar i = 0; i < QUEUE_SLOTS; i++) begin : g_cell
    slot_t left_s, right_s;
    if (i == 0) begin : g_head
      assign left_s = new_slot;
    end else begin : g_mid
      assign left_s = cur[i-1];
    end
    if (i == QUEUE_SLOTS - 1) begin : g_tail
      assign right_s = empty_slot;
    end else begin : g_body
      assign right_s = cur[i+1];
    end
    kdh_qcell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (qctl),
      .left_i  (left_s),
      .right_i (right_s),
      .hit_i   (hit[i]),
      .hit_o   (hit[i+1]),
      .cur_o   (cur[i]),
      .nxt_o   (nxt[i])
    );
  end

  // Report codes from the post-update queue.
  logic [CODE_W-1:0] rep_code [REPORT_SLOTS];
  for (genvar s = 0; s < REPORT_SLOTS; s++) begin : g_rep
    if (s < QUEUE_SLOTS) begin : g_used
      assign rep_code[s] = nxt[s].vld ? nxt[s].code : '0;
    end else begin : g_unused
      assign rep_code[s] = '0;
    end
  end

  // ---------------------------------------------------------------------
  // Sequential logic
  // ---------------------------------------------------------------------
  always_comb begin
    s1_vld_d = s1_vld_q;
    if (accept) begin
      s1_vld_d = 1'b1;
    end else if (s1_adv) begin
      s1_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (s1_adv && report_ev) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      mod_q     <= '0;
      hvld_q    <= '0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      out_vld_q <= out_vld_d;
      if (s1_adv) begin
        mod_q <= mod_d;
      end
      if (hist_we) begin
        hvld_q[waddr] <= 1'b1;
      end
    end
  end

  // Payload: request fields, valid-bit sample and forwarding of the
  // write-back that lands in the same cycle as this request's read.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_func_q   <= func_i;
      s1_key_q    <= key_ext;
      s1_down_q   <= key_down_i;
      s1_ismod_q  <= entry_is_modifier_i;
      s1_code_q   <= entry_code_i;
      s1_live_q   <= in_live;
      hv_q        <= hvld_q[raddr];
      hfwd_q      <= hist_we && (s1_key_q == key_ext);
      hfwd_data_q <= hist_wdata;
      lfwd_q      <= lay_we && (s1_key_q == key_ext);
      lfwd_data_q <= lay_wdata;
    end
    if (s1_adv && report_ev) begin
      evk_q  <= release_ev ? EVT_RELEASE : EVT_PRESS;
      modb_q <= mod_d;
      for (int s = 0; s < REPORT_SLOTS; s++) begin
        rslot_q[s] <= rep_code[s];
      end
    end
  end

  assign out_valid_o     = out_vld_q;
  assign event_kind_o    = evk_q;
  assign modifier_byte_o = modb_q;
  assign slot_0_o        = rslot_q[0];
  assign slot_1_o        = rslot_q[1];
  assign slot_2_o        = rslot_q[2];
  assign slot_3_o        = rslot_q[3];
  assign slot_4_o        = rslot_q[4];
  assign slot_5_o        = rslot_q[5];

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_one_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q |-> !(press_ev && release_ev))
    else $error("press and release decided for the same request");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_vld_q && out_vld_q && !out_ready_i))
    else $error("input held off without a stalled report");

  a_mod_press_sets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && press_ev && lay_type) |=> ((mod_q & $past(mod_q)) == $past(mod_q)))
    else $error("modifier press cleared a modifier bit");

  a_report_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !$past(out_vld_q)) |-> $past(s1_adv && report_ev))
    else $error("report appeared without a debounced event");

endmodule

`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench for key_debounce_hid_report: a directed table, then random traffic.
// Needs kdh_pkg and the block's RTL; model predicts reports, checked table rows give their own.
`timescale 1ns / 100ps

module testbench;
  import kdh_pkg::*;

  localparam int NUM_KEYS       = 128;
  localparam int QUEUE_SLOTS    = 6;
  localparam logic [7:0] EMPTY_SLOT = 8'd255;
  localparam int RANDOM_REQUESTS = 1700;
  localparam int POOL_KEYS       = 12;
  localparam int HOLD_AT         = 500;
  localparam int PAUSE_AT        = 1300;
  localparam int LONG_HOLD       = 400;
  localparam int TAIL_CYCLES     = 20;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int DIRECTED_ROWS   = 24;

  // One report as it leaves the block; slots[0] is the most recent key.
  typedef struct packed {
    logic                         kind;
    logic [7:0]                   mods;
    logic [REPORT_SLOTS-1:0][7:0] slots;
  } hid_report_t;

  // One row of the directed table; rpt is used only when checked is set.
  typedef struct packed {
    logic        func;
    logic [6:0]  key;
    logic        down;
    logic        is_mod;
    logic [7:0]  code;
    logic        checked;
    hid_report_t rpt;
  } directed_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       req_valid = 1'b0;
  logic       req_ready;
  logic       req_func = FUNC_SAMPLE;
  logic [6:0] req_key = '0;
  logic       req_down = 1'b0;
  logic       req_is_mod = 1'b0;
  logic [7:0] req_code = '0;
  logic       rpt_valid;
  logic       rpt_ready = 1'b0;
  logic       rpt_kind;
  logic [7:0] rpt_mods;
  logic [7:0] rpt_slot [REPORT_SLOTS];

  // Predictor state: per-key history, held flag and layout, recency queue, modifiers.
  logic [7:0] key_history   [NUM_KEYS];
  bit         key_held      [NUM_KEYS];
  bit         layout_is_mod [NUM_KEYS];
  logic [7:0] layout_code   [NUM_KEYS];
  logic [7:0] recency       [QUEUE_SLOTS];
  logic [7:0] mod_state;

  hid_report_t pending_reports [$];
  int  error_count = 0;
  int  burst_left  = 0;
  int  idle_cycles = 0;
  bit  long_hold_req  = 1'b0;
  bit  long_hold_done = 1'b0;

  // Directed table. Key 0 is a plain key with code 04, key 127 a modifier with
  // the full mask. Press key 0, press key 127, release key 0, then rewrite the
  // layout of key 127 while it is still held down.
  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{FUNC_LOAD,   7'd0,   1'b0, 1'b0, 8'h04, 1'b0, '0},
    '{FUNC_LOAD,   7'd127, 1'b0, 1'b1, 8'hFF, 1'b0, '0},
    '{FUNC_SAMPLE, 7'd0,   1'b1, 1'b0, 8'h00, 1'b0, '0},
    '{FUNC_SAMPLE, 7'd0,   1'b1, 1'b0, 8'h00, 1'b0, '0},
    '{FUNC_SAMPLE, 7'd0,   1'b1, 1'b0, 8'h00, 1'b0, '0},
    '{FUNC_SAMPLE, 7'd0,   1'b1, 1'b0, 8'h00, 1'b0, '0},
    '{FUNC_SAMPLE, 7'd0,   1'b1, 1'b0, 8'h00, 1'b0, '0},
    '{FUNC_SAMPLE, 7'd0,   1'b1, 1'b0, 8'h00, 1'b0, '0},
    '{FUNC_SAMPLE, 7'd0,   1'b1, 1'b0, 8'h00, 1'b1,
      '{EVT_PRESS, 8'h00, {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h04}}},
    '{FUNC_SAMPLE, 7'd127, 1'b1, 1'b0, 8'hFF, 1'b0, '0},
    '{FUNC_SAMPLE, 7'd127, 1'b1, 1'b1, 8'hFF, 1'b0, '0},
    '{FUNC_SAMPLE, 7'd127, 1'b1, 1'b0, 8'h00, 1'b0, '0},
    '{FUNC_SAMPLE, 7'd127, 1'b1, 1'b1, 8'h00, 1'b0, '0},
    '{FUNC_SAMPLE, 7'd127, 1'b1, 1'b0, 8'hFF, 1'b0, '0},
    '{FUNC_SAMPLE, 7'd127, 1'b1, 1'b1, 8'hFF, 1'b0, '0},
    '{FUNC_SAMPLE, 7'd127, 1'b1, 1'b0, 8'h00, 1'b1,
      '{EVT_PRESS, 8'hFF, {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h04}}},
    '{FUNC_SAMPLE, 7'd0,   1'b0, 1'b0, 8'h00, 1'b0, '0},
    '{FUNC_SAMPLE, 7'd0,   1'b0, 1'b0, 8'h00, 1'b0, '0},
    '{FUNC_SAMPLE, 7'd0,   1'b0, 1'b0, 8'h00, 1'b0, '0},
    '{FUNC_SAMPLE, 7'd0,   1'b0, 1'b0, 8'h00, 1'b0, '0},
    '{FUNC_SAMPLE, 7'd0,   1'b0, 1'b0, 8'h00, 1'b0, '0},
    '{FUNC_SAMPLE, 7'd0,   1'b0, 1'b0, 8'h00, 1'b0, '0},
    '{FUNC_SAMPLE, 7'd0,   1'b0, 1'b0, 8'h00, 1'b1,
      '{EVT_RELEASE, 8'hFF, {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}}},
    '{FUNC_LOAD,   7'd127, 1'b0, 1'b1, 8'h0F, 1'b0, '0}
  };

  key_debounce_hid_report #(
    .NUM_KEYS    (NUM_KEYS),
    .QUEUE_SLOTS (QUEUE_SLOTS)
  ) u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (req_valid),
    .in_ready_o          (req_ready),
    .func_i              (req_func),
    .key_index_i         (req_key),
    .key_down_i          (req_down),
    .entry_is_modifier_i (req_is_mod),
    .entry_code_i        (req_code),
    .out_valid_o         (rpt_valid),
    .out_ready_i         (rpt_ready),
    .event_kind_o        (rpt_kind),
    .modifier_byte_o     (rpt_mods),
    .slot_0_o            (rpt_slot[0]),
    .slot_1_o            (rpt_slot[1]),
    .slot_2_o            (rpt_slot[2]),
    .slot_3_o            (rpt_slot[3]),
    .slot_4_o            (rpt_slot[4]),
    .slot_5_o            (rpt_slot[5])
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Advance the predictor by one accepted request; return 1 when it yields a report.
  function automatic bit predict_report(input logic f, input logic [6:0] k, input logic down,
                                        input logic is_mod, input logic [7:0] code,
                                        output hid_report_t rpt);
    logic [7:0] h;
    int         pos;
    bit         fired;
    fired = 1'b0;
    rpt   = '0;
    // Drop indexes beyond the key count; unreachable at 128 keys, kept for smaller builds.
    if (int'(k) >= NUM_KEYS) return 1'b0;
    if (f == FUNC_LOAD) begin
      layout_is_mod[k] = is_mod;
      layout_code[k]   = code;
      return 1'b0;
    end
    h = key_history[k] | {7'd0, down};
    if (h == PRESS_PAT && !key_held[k]) begin
      key_held[k] = 1'b1;
      if (layout_is_mod[k]) begin
        mod_state = mod_state | layout_code[k];
      end else begin
        // Push to the front; the oldest entry falls off the end.
        for (int i = QUEUE_SLOTS - 1; i > 0; i--) recency[i] = recency[i-1];
        recency[0] = {1'b0, k};
      end
      rpt.kind = EVT_PRESS;
      fired    = 1'b1;
    end else if (h == RELEASE_PAT && key_held[k]) begin
      key_held[k] = 1'b0;
      if (layout_is_mod[k]) begin
        mod_state = mod_state & ~layout_code[k];
      end else begin
        // Remove the key if it is still queued and close the gap behind it.
        pos = QUEUE_SLOTS;
        for (int i = QUEUE_SLOTS - 1; i >= 0; i--)
          if (recency[i] == {1'b0, k}) pos = i;
        if (pos < QUEUE_SLOTS) begin
          for (int j = pos; j < QUEUE_SLOTS - 1; j++) recency[j] = recency[j+1];
          recency[QUEUE_SLOTS-1] = EMPTY_SLOT;
        end
      end
      rpt.kind = EVT_RELEASE;
      fired    = 1'b1;
    end
    key_history[k] = h << 1;
    if (fired) begin
      rpt.mods = mod_state;
      for (int s = 0; s < REPORT_SLOTS; s++)
        if (s < QUEUE_SLOTS && recency[s] != EMPTY_SLOT && int'(recency[s]) < NUM_KEYS)
          rpt.slots[s] = layout_code[recency[s][6:0]];
    end
    return fired;
  endfunction

  // Offer one request, hold it until accepted, then record what it should produce.
  // Insert a random gap first whenever the current burst has run out.
  task automatic send_request(input logic f, input logic [6:0] k, input logic down,
                              input logic is_mod, input logic [7:0] code,
                              input bit typed, input hid_report_t typed_rpt);
    hid_report_t rpt;
    bit          fired;
    int          gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      repeat (gap) begin
        @(negedge clk_i);
        req_valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk_i);
    req_valid  <= 1'b1;
    req_func   <= f;
    req_key    <= k;
    req_down   <= down;
    req_is_mod <= is_mod;
    req_code   <= code;
    do @(posedge clk_i); while (!req_ready);
    fired = predict_report(f, k, down, is_mod, code, rpt);
    if (typed) pending_reports.push_back(typed_rpt);
    else if (fired) pending_reports.push_back(rpt);
  endtask

  // Compare every accepted report against the oldest expectation.
  always @(posedge clk_i) begin
    hid_report_t got;
    hid_report_t want;
    if (rst_ni && rpt_valid && rpt_ready) begin
      got.kind = rpt_kind;
      got.mods = rpt_mods;
      for (int s = 0; s < REPORT_SLOTS; s++) got.slots[s] = rpt_slot[s];
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected report kind %0d mods %02h", $time, got.kind, got.mods);
        error_count++;
      end else begin
        want = pending_reports.pop_front();
        if (got.kind !== want.kind) begin
          $display("%0t: event kind expected %0d got %0d", $time, want.kind, got.kind);
          error_count++;
        end
        if (got.mods !== want.mods) begin
          $display("%0t: modifier byte expected %02h got %02h", $time, want.mods, got.mods);
          error_count++;
        end
        for (int s = 0; s < REPORT_SLOTS; s++)
          if (got.slots[s] !== want.slots[s]) begin
            $display("%0t: slot %0d expected %02h got %02h",
                     $time, s, want.slots[s], got.slots[s]);
            error_count++;
          end
      end
    end
  end

  // Watchdog: end the run when neither channel moves for too long.
  always @(posedge clk_i) begin
    if ((req_valid && req_ready) || (rpt_valid && rpt_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: segments of always-ready, random stalls and a fixed duty pattern,
  // plus one long hold-off on request so the block backs up into its input.
  initial begin
    int mode;
    int len;
    @(posedge rst_ni);
    forever begin
      if (long_hold_req && !long_hold_done) begin
        repeat (LONG_HOLD) begin
          @(negedge clk_i);
          rpt_ready <= 1'b0;
        end
        long_hold_done = 1'b1;
      end else begin
        mode = $urandom_range(0, 2);
        len  = $urandom_range(10, 80);
        for (int c = 0; c < len; c++) begin
          @(negedge clk_i);
          case (mode)
            0: begin
              rpt_ready <= 1'b1;
            end
            1: begin
              rpt_ready <= ($urandom_range(0, 2) == 0);
            end
            default: begin
              rpt_ready <= (c % 4 == 0);
            end
          endcase
        end
      end
    end
  end

  initial begin
    int          pool_key [POOL_KEYS];
    bit          pool_lvl [POOL_KEYS];
    int          pool_run [POOL_KEYS];
    int          p;
    int          pick;
    hid_report_t none;
    none = '0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      key_history[i]   = '0;
      key_held[i]      = 1'b0;
      layout_is_mod[i] = 1'b0;
      layout_code[i]   = '0;
    end
    for (int i = 0; i < QUEUE_SLOTS; i++) recency[i] = EMPTY_SLOT;
    mod_state = '0;

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Load every layout entry first so no sample ever reads an unwritten one.
    for (int i = 0; i < NUM_KEYS; i++)
      send_request(FUNC_LOAD, i[6:0], 1'($urandom_range(0, 1)),
                   ($urandom_range(0, 3) == 0), 8'($urandom_range(0, 255)), 1'b0, none);

    foreach (directed_rows[r])
      send_request(directed_rows[r].func, directed_rows[r].key, directed_rows[r].down,
                   directed_rows[r].is_mod, directed_rows[r].code,
                   directed_rows[r].checked, directed_rows[r].rpt);

    // Each pool key alternates runs of closed and open samples; runs of seven or
    // more debounce, shorter runs act as bounce. More pool keys than queue slots
    // push old keys out, so some releases find their key already dropped.
    for (int i = 0; i < POOL_KEYS; i++) begin
      pool_key[i] = $urandom_range(0, NUM_KEYS - 1);
      pool_lvl[i] = 1'b0;
      pool_run[i] = $urandom_range(7, 12);
    end

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == HOLD_AT) long_hold_req = 1'b1;
      if (n == PAUSE_AT) begin
        // Hold the sender until every outstanding report has come out.
        @(negedge clk_i);
        req_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge clk_i);
      end
      pick = $urandom_range(0, 99);
      if (pick < 82) begin
        p = $urandom_range(0, POOL_KEYS - 1);
        send_request(FUNC_SAMPLE, pool_key[p][6:0], pool_lvl[p], 1'($urandom_range(0, 1)),
                     8'($urandom_range(0, 255)), 1'b0, none);
        pool_run[p]--;
        if (pool_run[p] == 0) begin
          pool_lvl[p] = !pool_lvl[p];
          pool_run[p] = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 6)
                                                      : $urandom_range(7, 12);
          if (pool_lvl[p] && $urandom_range(0, 7) == 0)
            pool_key[p] = $urandom_range(0, NUM_KEYS - 1);
        end
      end else if (pick < 92) begin
        // Noise: a stray sample on any key.
        send_request(FUNC_SAMPLE, 7'($urandom_range(0, NUM_KEYS - 1)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     8'($urandom_range(0, 255)), 1'b0, none);
      end else begin
        // Rewrite a layout entry, possibly while that key is held or queued.
        send_request(FUNC_LOAD, 7'($urandom_range(0, NUM_KEYS - 1)),
                     1'($urandom_range(0, 1)), ($urandom_range(0, 2) == 0),
                     8'($urandom_range(0, 255)), 1'b0, none);
      end
    end

    @(negedge clk_i);
    req_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    // Give any stray late report time to show up.
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
